// ----- design/hsv_to_rgb_hue_stepper_unit_defines.svh -----
// assertion macros shared by the hsv to rgb hue stepper rtl
`ifndef HSV_TO_RGB_HUE_STEPPER_UNIT_DEFINES_SVH
`define HSV_TO_RGB_HUE_STEPPER_UNIT_DEFINES_SVH

// same-cycle implication
`define HSVRGB_ASSERT_IMPLY(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);

// next-cycle implication
`define HSVRGB_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);

`endif

// ----- design/hsvrgb_pkg.sv -----
// types and constants of the hsv to rgb hue stepper
`default_nettype none

package hsvrgb_pkg;

  localparam int unsigned HUE_W = 16;

  localparam logic [HUE_W-1:0] HUE_STEP_RST = 16'd40503;

  localparam logic [1:0] FUNC_CONVERT = 2'd0;
  localparam logic [1:0] FUNC_STEP    = 2'd1;
  localparam logic [1:0] FUNC_LOAD    = 2'd2;

  localparam logic [2:0] SECT_RED_YEL = 3'd0;
  localparam logic [2:0] SECT_YEL_GRN = 3'd1;
  localparam logic [2:0] SECT_GRN_CYN = 3'd2;
  localparam logic [2:0] SECT_CYN_BLU = 3'd3;
  localparam logic [2:0] SECT_BLU_MAG = 3'd4;

  typedef struct packed {
    logic [1:0]       func;
    logic [HUE_W-1:0] hue_in;
    logic [7:0]       sat_in;
    logic [7:0]       val_in;
  } hsvrgb_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsvrgb_out_t;

  // floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

// ----- design/hsvrgb_fifo.sv -----
// small register queue
`default_nettype none

module hsvrgb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            full,
  output logic                            empty,
  output logic      [$clog2(DEPTH):0]     count
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ((wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ((rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- design/hsvrgb_front.sv -----
// front end: accepts beats, keeps the stored hue and the step register
`default_nettype none

`include "hsv_to_rgb_hue_stepper_unit_defines.svh"

module hsvrgb_front #(
  parameter int unsigned HUE_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire hsvrgb_pkg::hsvrgb_in_t     in_data,
  input  wire logic                       q_full,
  input  wire logic                       cfg_valid,
  input  wire logic [hsvrgb_pkg::HUE_W-1:0] cfg_data,
  output logic                            cfg_ready,
  output logic                            q_push,
  output logic      [HUE_BITS-1:0]        q_hue,
  output logic      [7:0]                 q_sat,
  output logic      [7:0]                 q_val
);

  import hsvrgb_pkg::*;

  localparam int unsigned SHW = (HUE_BITS < HUE_W) ? HUE_BITS : HUE_W;

  logic [SHW-1:0]            stored_hue_r, stored_hue_nxt;
  logic [HUE_W-1:0]          hue_step_r, hue_step_nxt;
  logic [SHW-1:0]            stored_sum;
  logic [HUE_BITS+HUE_W-1:0] in_ext;
  logic [HUE_BITS+SHW-1:0]   sum_ext;
  logic                      accept;
  logic                      cfg_wr;

  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid && cfg_ready;
  assign accept     = push && !q_full;
  assign q_push     = accept;
  assign stored_sum = stored_hue_r + hue_step_r[SHW-1:0];
  assign in_ext     = {{HUE_BITS{1'b0}}, in_data.hue_in};
  assign sum_ext    = {{HUE_BITS{1'b0}}, stored_sum};

  always_comb begin
    stored_hue_nxt = stored_hue_r;
    q_hue          = in_ext[HUE_BITS-1:0];
    q_sat          = in_data.sat_in;
    q_val          = in_data.val_in;
    unique case (in_data.func)
      FUNC_STEP: begin
        stored_hue_nxt = stored_sum;
        q_hue          = sum_ext[HUE_BITS-1:0];
        q_sat          = 8'hff;
        q_val          = 8'hff;
      end
      FUNC_LOAD: begin
        stored_hue_nxt = in_data.hue_in[SHW-1:0];
      end
      default: begin
        stored_hue_nxt = stored_hue_r;
      end
    endcase
    hue_step_nxt = cfg_wr ? cfg_data : hue_step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_hue_r <= '0;
      hue_step_r   <= HUE_STEP_RST;
    end else begin
      if (accept) begin
        stored_hue_r <= stored_hue_nxt;
      end
      hue_step_r <= hue_step_nxt;
    end
  end

  `HSVRGB_ASSERT_NEXT(a_step_adds, clk, rst_n, accept && (in_data.func == FUNC_STEP), stored_hue_r == $past(stored_sum), "stored hue did not advance by the step")

endmodule

`default_nettype wire

// ----- design/hsvrgb_back.sv -----
// back end: sector split, channel levels and output write
`default_nettype none

`include "hsv_to_rgb_hue_stepper_unit_defines.svh"

module hsvrgb_back #(
  parameter int unsigned HUE_BITS  = 16,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  input  wire logic [HUE_BITS-1:0]          q_hue,
  input  wire logic [7:0]                   q_sat,
  input  wire logic [7:0]                   q_val,
  output logic                              q_pop,
  input  wire logic [$clog2(OUT_DEPTH):0]   out_count,
  output logic                              res_push,
  output hsvrgb_pkg::hsvrgb_out_t           res_data
);

  import hsvrgb_pkg::*;

  localparam int unsigned CW = $clog2(OUT_DEPTH) + 1;

  logic [HUE_BITS+2:0]  p;
  logic [2:0]           sector;
  logic [HUE_BITS-1:0]  rem;
  logic [HUE_BITS:0]    f;
  logic [15:0]          vs;
  logic [CW:0]          inflight;
  logic                 issue;

  logic                 s1_v_r, s1_v_nxt;
  logic [2:0]           s1_sector_r;
  logic [HUE_BITS:0]    s1_f_r;
  logic [7:0]           s1_val_r;
  logic [15:0]          s1_vs_r;

  logic [15:0]          low;
  logic [HUE_BITS+16:0] prod;

  logic                 s2_v_r, s2_v_nxt;
  logic [2:0]           s2_sector_r;
  logic [7:0]           s2_val_r;
  logic [15:0]          s2_low_r;
  logic [15:0]          s2_pf_r;

  logic [16:0]          t;
  logic [7:0]           top, bot, ramp;

  assign inflight = {1'b0, out_count} + (CW+1)'(s1_v_r) + (CW+1)'(s2_v_r);
  assign issue    = !q_empty && (inflight < (CW+1)'(OUT_DEPTH));
  assign q_pop    = issue;
  assign s1_v_nxt = issue;
  assign s2_v_nxt = s1_v_r;

  always_comb begin
    p      = ({3'b0, q_hue} << 2) + ({3'b0, q_hue} << 1);
    sector = p[HUE_BITS+2:HUE_BITS];
    rem    = p[HUE_BITS-1:0];
    f      = sector[0] ? (((HUE_BITS+1)'(1) << HUE_BITS) - {1'b0, rem}) : {1'b0, rem};
    vs     = {8'b0, q_sat} * {8'b0, q_val};
  end

  always_comb begin
    low  = {s1_val_r, 8'b0} - {8'b0, s1_val_r} - s1_vs_r;
    prod = {{(HUE_BITS+1){1'b0}}, s1_vs_r} * {16'b0, s1_f_r};
  end

  always_comb begin
    t    = {1'b0, s2_low_r} + {1'b0, s2_pf_r};
    top  = s2_val_r;
    bot  = div255(s2_low_r);
    ramp = div255(t[15:0]);
    case (s2_sector_r)
      SECT_RED_YEL: res_data = '{red: top,  green: ramp, blue: bot};
      SECT_YEL_GRN: res_data = '{red: ramp, green: top,  blue: bot};
      SECT_GRN_CYN: res_data = '{red: bot,  green: top,  blue: ramp};
      SECT_CYN_BLU: res_data = '{red: bot,  green: ramp, blue: top};
      SECT_BLU_MAG: res_data = '{red: ramp, green: bot,  blue: top};
      default:      res_data = '{red: top,  green: bot,  blue: ramp};
    endcase
    res_push = s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_sector_r <= sector;
    s1_f_r      <= f;
    s1_val_r    <= q_val;
    s1_vs_r     <= vs;
    s2_sector_r <= s1_sector_r;
    s2_val_r    <= s1_val_r;
    s2_low_r    <= low;
    s2_pf_r     <= prod[HUE_BITS+15:HUE_BITS];
  end

  `HSVRGB_ASSERT_IMPLY(a_credit_room, clk, rst_n, s2_v_r, out_count < CW'(OUT_DEPTH), "result written into a full queue")
  `HSVRGB_ASSERT_IMPLY(a_credit_bound, clk, rst_n, 1'b1, inflight <= (CW+1)'(OUT_DEPTH), "more beats in flight than queue slots")
  `HSVRGB_ASSERT_NEXT(a_pipe_flow, clk, rst_n, s1_v_r, s2_v_r, "beat lost between stages")

endmodule

`default_nettype wire

// ----- design/hsv_to_rgb_hue_stepper_unit.sv -----
// HSV to RGB converter with hue stepper: top level
//
// Input channel: in_data carries func, hue_in, sat_in and val_in; a beat is
// taken at a clock edge with push high and full low. func 0 converts hue_in,
// func 1 adds the step register to the stored hue and converts it at full
// saturation and value, func 2 loads the stored hue from hue_in and converts.
// Result channel: out_data holds red, green and blue of the oldest result
// while empty is low; pop high with empty low takes it. One result per beat,
// in order.
// Config: cfg_data is the hue step, written when cfg_valid is high (ready is
// always high); write it only while no beat is in flight.
// Throughput: one beat per cycle while pop keeps up with the results, held by
// the two-stage multiply pipeline in the back end and a 4-entry result queue.
// Reset (rst_n low, synchronous): queues empty, stored hue 0, step 40503.
// When pop stays low the result queue fills, the back end stops taking work,
// the 2-entry middle queue fills and full rises; nothing is dropped.
`default_nettype none

module hsv_to_rgb_hue_stepper_unit #(
  parameter int unsigned HUE_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire hsvrgb_pkg::hsvrgb_in_t       in_data,
  output logic                              full,
  output logic                              empty,
  input  wire logic                         pop,
  output hsvrgb_pkg::hsvrgb_out_t           out_data,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [hsvrgb_pkg::HUE_W-1:0] cfg_data
);

  import hsvrgb_pkg::*;

  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned MID_W     = HUE_BITS + 16;

  logic                       mid_push, mid_pop, mid_full, mid_empty;
  logic [HUE_BITS-1:0]        f_hue;
  logic [7:0]                 f_sat, f_val;
  logic [MID_W-1:0]           mid_rdata;
  logic [$clog2(MID_DEPTH):0] mid_count;
  logic                       res_push;
  hsvrgb_out_t                res_data;
  logic [$clog2(OUT_DEPTH):0] out_count;
  logic                       out_full;

  assign full = mid_full;

  hsvrgb_front #(
    .HUE_BITS (HUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .q_full    (mid_full),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .q_push    (mid_push),
    .q_hue     (f_hue),
    .q_sat     (f_sat),
    .q_val     (f_val)
  );

  hsvrgb_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata ({f_hue, f_sat, f_val}),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .full  (mid_full),
    .empty (mid_empty),
    .count (mid_count)
  );

  hsvrgb_back #(
    .HUE_BITS  (HUE_BITS),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (mid_empty || (mid_count == '0)),
    .q_hue     (mid_rdata[MID_W-1:16]),
    .q_sat     (mid_rdata[15:8]),
    .q_val     (mid_rdata[7:0]),
    .q_pop     (mid_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  hsvrgb_fifo #(
    .WIDTH ($bits(hsvrgb_out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .pop   (pop),
    .rdata (out_data),
    .full  (out_full),
    .empty (empty),
    .count (out_count)
  );

endmodule

`default_nettype wire

// ----- tb/hsv_to_rgb_hue_stepper_unit_tb.sv -----
// testbench for the hsv to rgb hue stepper: directed and random beats checked by a color predictor
`timescale 1ns / 1ps

module hsv_to_rgb_hue_stepper_unit_tb;
  import hsvrgb_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  hsvrgb_in_t in_data = '0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic [HUE_W-1:0] cfg_data = '0;
  logic full;
  logic empty;
  logic cfg_ready;
  hsvrgb_out_t out_data;

  hsvrgb_in_t pending_beats[$];
  hsvrgb_out_t color_expect[$];
  hsvrgb_out_t want_color;
  logic [HUE_W-1:0] stored_hue_copy = '0;
  logic [HUE_W-1:0] hue_step_copy = HUE_STEP_RST;
  bit idle_mode = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int result_cnt = 0;
  int mismatch_cnt = 0;
  int quiet_cycles = 0;

  hsv_to_rgb_hue_stepper_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic hsvrgb_out_t hsv_color(input logic [15:0] hue, input logic [7:0] sat,
                                            input logic [7:0] val);
    logic [18:0] scaled;
    logic [2:0] sector;
    logic [16:0] ramp_frac;
    logic [15:0] vs;
    logic [15:0] low;
    logic [7:0] bot;
    logic [7:0] ramp;
    longint unsigned num;
    hsvrgb_out_t rgb;
    scaled = {3'b0, hue} * 19'd6;
    sector = scaled[18:16];
    vs = {8'b0, val} * {8'b0, sat};
    low = 16'd255 * {8'b0, val} - vs;
    bot = 8'(low / 16'd255);
    ramp_frac = sector[0] ? 17'h10000 - {1'b0, scaled[15:0]} : {1'b0, scaled[15:0]};
    num = (longint'(low) << 16) + longint'(vs) * longint'(ramp_frac);
    ramp = 8'(num / (longint'(255) << 16));
    case (sector)
      SECT_RED_YEL: rgb = '{red: val, green: ramp, blue: bot};
      SECT_YEL_GRN: rgb = '{red: ramp, green: val, blue: bot};
      SECT_GRN_CYN: rgb = '{red: bot, green: val, blue: ramp};
      SECT_CYN_BLU: rgb = '{red: bot, green: ramp, blue: val};
      SECT_BLU_MAG: rgb = '{red: ramp, green: bot, blue: val};
      default:      rgb = '{red: val, green: bot, blue: ramp};
    endcase
    return rgb;
  endfunction

  // in idle mode mostly back to back, some short gaps, a few long ones; otherwise always back to back
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_mode || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [7:0] rand_level();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  task automatic queue_beat(input logic [1:0] func, input logic [15:0] hue,
                            input logic [7:0] sat, input logic [7:0] val);
    pending_beats.push_back('{func: func, hue_in: hue, sat_in: sat, val_in: val});
  endtask

  // look after the edge has settled
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_beats.size() != 0 || push || color_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_hue_step(input logic [HUE_W-1:0] step);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= step;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hue_step_copy = step;
  endtask

  // driver: predicts each accepted beat, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      send_gap = 0;
      stored_hue_copy = '0;
      hue_step_copy = HUE_STEP_RST;
    end else begin
      if (push && !full) begin
        case (in_data.func)
          FUNC_STEP: begin
            stored_hue_copy = stored_hue_copy + hue_step_copy;
            color_expect.push_back(hsv_color(stored_hue_copy, 8'hFF, 8'hFF));
          end
          FUNC_LOAD: begin
            stored_hue_copy = in_data.hue_in;
            color_expect.push_back(hsv_color(stored_hue_copy, in_data.sat_in, in_data.val_in));
          end
          default: begin
            color_expect.push_back(hsv_color(in_data.hue_in, in_data.sat_in, in_data.val_in));
          end
        endcase
      end
      if (!push || !full) begin
        if (send_gap != 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          in_data <= pending_beats.pop_front();
          push <= 1'b1;
          send_gap = pick_gap();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each popped beat, holds off twice for a long stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        if (color_expect.size() == 0) begin
          $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                   out_data.red, out_data.green, out_data.blue);
          mismatch_cnt++;
        end else begin
          want_color = color_expect.pop_front();
          if (out_data.red !== want_color.red) begin
            $display("%0t: red expected %0d, actual %0d", $time, want_color.red, out_data.red);
            mismatch_cnt++;
          end
          if (out_data.green !== want_color.green) begin
            $display("%0t: green expected %0d, actual %0d", $time,
                     want_color.green, out_data.green);
            mismatch_cnt++;
          end
          if (out_data.blue !== want_color.blue) begin
            $display("%0t: blue expected %0d, actual %0d", $time, want_color.blue, out_data.blue);
            mismatch_cnt++;
          end
        end
        result_cnt++;
        if (result_cnt == 200 || result_cnt == 950) stall_left = HOLD_CYCLES;
        else stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("hsv_to_rgb_hue_stepper_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    hsvrgb_in_t beat;
    int sel;
    int run;
    logic [HUE_W-1:0] phase_step[6];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: sector edges, level extremes, spare code, step wrap
    queue_beat(FUNC_LOAD, 16'h0000, 8'hFF, 8'hFF);
    repeat (3) queue_beat(FUNC_STEP, 16'hFFFF, 8'h00, 8'h00);
    queue_beat(FUNC_CONVERT, 16'h0000, 8'hFF, 8'hFF);
    queue_beat(FUNC_CONVERT, 16'hFFFF, 8'hFF, 8'hFF);
    queue_beat(FUNC_CONVERT, 16'd10922, 8'hFF, 8'hFF);
    queue_beat(FUNC_CONVERT, 16'd10923, 8'hFF, 8'hFF);
    queue_beat(FUNC_CONVERT, 16'd21845, 8'hC0, 8'hFF);
    queue_beat(FUNC_CONVERT, 16'd21846, 8'hFF, 8'hC0);
    queue_beat(FUNC_CONVERT, 16'd32768, 8'h80, 8'h80);
    queue_beat(FUNC_CONVERT, 16'd43690, 8'hFF, 8'hFF);
    queue_beat(FUNC_CONVERT, 16'd43691, 8'h01, 8'hFF);
    queue_beat(FUNC_CONVERT, 16'd54613, 8'hFF, 8'h01);
    queue_beat(FUNC_CONVERT, 16'd54614, 8'hFF, 8'hFF);
    queue_beat(FUNC_CONVERT, 16'h5555, 8'h00, 8'h00);
    queue_beat(FUNC_CONVERT, 16'hAAAA, 8'h00, 8'hFF);
    queue_beat(FUNC_CONVERT, 16'h2000, 8'hFF, 8'h00);
    queue_beat(FUNC_CONVERT, 16'h7FFF, 8'h7F, 8'h80);
    queue_beat(FUNC_SPARE, 16'h1234, 8'h80, 8'hC0);
    queue_beat(FUNC_STEP, 16'h0000, 8'hFF, 8'hFF);
    queue_beat(FUNC_LOAD, 16'hFFFF, 8'h00, 8'hFF);
    queue_beat(FUNC_STEP, 16'h0000, 8'h00, 8'h00);
    queue_beat(FUNC_STEP, 16'h0000, 8'h00, 8'h00);
    wait_drained();

    phase_step = '{HUE_STEP_RST, 16'h0000, 16'hFFFF, 16'h0001, 16'($urandom), 16'h8000};
    foreach (phase_step[ph]) begin
      if (ph != 0) write_hue_step(phase_step[ph]);
      idle_mode = (ph % 3 != 2);
      for (int n = 0; n < 290; ) begin
        sel = $urandom_range(0, 9);
        beat.hue_in = 16'($urandom);
        beat.sat_in = rand_level();
        beat.val_in = rand_level();
        if (sel < 3) begin
          // a loaded hue followed by a run of steps
          beat.func = FUNC_LOAD;
          pending_beats.push_back(beat);
          n++;
          run = $urandom_range(1, 10);
          repeat (run) begin
            beat.func = FUNC_STEP;
            beat.hue_in = 16'($urandom);
            beat.sat_in = 8'($urandom);
            beat.val_in = 8'($urandom);
            pending_beats.push_back(beat);
            n++;
          end
        end else begin
          beat.func = 2'($urandom_range(0, 3));
          pending_beats.push_back(beat);
          n++;
        end
      end
      wait_drained();
    end

    if (mismatch_cnt == 0 && color_expect.size() == 0) begin
      $display("hsv_to_rgb_hue_stepper_unit test passed");
    end else begin
      $display("hsv_to_rgb_hue_stepper_unit test failed");
    end
    $finish;
  end

endmodule
